// ===== rtl/scan_track_aim_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// scan_track_aim_controller_unit_macros
// Assertion helpers used by scan_track_aim_controller_unit.
// ----------------------------------------------------------------------------
`ifndef SCAN_TRACK_AIM_CONTROLLER_UNIT_MACROS_SVH
`define SCAN_TRACK_AIM_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scta_pkg.sv =====
// ----------------------------------------------------------------------------
// scta_pkg
// Shared constants, codes and types of the scan/track/aim controller.
// ----------------------------------------------------------------------------
package scta_pkg;

  // Fixed field widths
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned FLAG_W     = 8;
  localparam int unsigned ANGLE_W    = 19;
  localparam int unsigned LIMIT_W    = 18;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned WIN_W      = 17;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned GAIN_FRAC_BITS = 24;

  // Parameter defaults
  localparam int unsigned FRAME_WIDTH_DEF     = 640;
  localparam int unsigned COORD_BITS_DEF      = 10;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DETECT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FLAG   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOWER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_UPPER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H_WINDOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V_WINDOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_INTERVAL = 3'd7;

  // Register reset values
  localparam logic signed [LIMIT_W-1:0] RST_ANGLE_LOWER   = -18'sd102892;
  localparam logic signed [LIMIT_W-1:0] RST_ANGLE_UPPER   = 18'sd102892;
  localparam logic [STEP_W-1:0]         RST_STEP_SIZE     = 16'd393;
  localparam logic [GAIN_W-1:0]         RST_PIXEL_GAIN    = 20'd23425;
  localparam logic [WIN_W-1:0]          RST_H_WINDOW      = 17'd3932;
  localparam logic [WIN_W-1:0]          RST_V_WINDOW      = 17'd1966;
  localparam logic [TICK_W-1:0]         RST_LOST_TIMEOUT  = 8'd10;
  localparam logic [TICK_W-1:0]         RST_FIRE_INTERVAL = 8'd40;

  localparam logic [TICK_W-1:0] AGE_MAX = 8'hFF;

  localparam logic signed [FLAG_W-1:0] FLAG_ARM = 8'sd1;

  // Fire codes
  localparam logic [CODE_W-1:0] FIRE_HIGH = 8'd180;
  localparam logic [CODE_W-1:0] FIRE_MID  = 8'd150;
  localparam logic [CODE_W-1:0] FIRE_LOW  = 8'd120;
  localparam logic [CODE_W-1:0] FIRE_NONE = 8'd0;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] angle_lower;
    logic signed [LIMIT_W-1:0] angle_upper;
    logic [STEP_W-1:0]         step_size;
    logic [GAIN_W-1:0]         pixel_gain;
    logic [WIN_W-1:0]          h_window;
    logic [WIN_W-1:0]          v_window;
    logic [TICK_W-1:0]         lost_timeout;
    logic [TICK_W-1:0]         fire_interval;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] aim_angle;
    logic                      fire;
    logic [CODE_W-1:0]         fire_value;
  } res_t;

endpackage

// ===== rtl/scta_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scta_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module scta_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [scta_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [scta_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output scta_pkg::cfg_t                   cfg_o
);
  import scta_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ANGLE_LOWER:   cfg_d.angle_lower   = cfg_data_i[LIMIT_W-1:0];
        REG_ANGLE_UPPER:   cfg_d.angle_upper   = cfg_data_i[LIMIT_W-1:0];
        REG_STEP_SIZE:     cfg_d.step_size     = cfg_data_i[STEP_W-1:0];
        REG_PIXEL_GAIN:    cfg_d.pixel_gain    = cfg_data_i[GAIN_W-1:0];
        REG_H_WINDOW:      cfg_d.h_window      = cfg_data_i[WIN_W-1:0];
        REG_V_WINDOW:      cfg_d.v_window      = cfg_data_i[WIN_W-1:0];
        REG_LOST_TIMEOUT:  cfg_d.lost_timeout  = cfg_data_i[TICK_W-1:0];
        REG_FIRE_INTERVAL: cfg_d.fire_interval = cfg_data_i[TICK_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_lower   <= RST_ANGLE_LOWER;
      cfg_q.angle_upper   <= RST_ANGLE_UPPER;
      cfg_q.step_size     <= RST_STEP_SIZE;
      cfg_q.pixel_gain    <= RST_PIXEL_GAIN;
      cfg_q.h_window      <= RST_H_WINDOW;
      cfg_q.v_window      <= RST_V_WINDOW;
      cfg_q.lost_timeout  <= RST_LOST_TIMEOUT;
      cfg_q.fire_interval <= RST_FIRE_INTERVAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/scta_aim_core.sv =====
// ----------------------------------------------------------------------------
// scta_aim_core
// Controller state and per-event update: target tracking, sweep and firing.
// ----------------------------------------------------------------------------
module scta_aim_core #(
  parameter int unsigned FRAME_WIDTH     = scta_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned COORD_BITS      = scta_pkg::COORD_BITS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = scta_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [scta_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [COORD_BITS-1:0]               box_x_i,
  input  logic [COORD_BITS-1:0]               box_y_i,
  input  logic [COORD_BITS-1:0]               box_width_i,
  input  logic [COORD_BITS-1:0]               box_height_i,
  input  logic signed [scta_pkg::FLAG_W-1:0]  flag_value_i,
  input  scta_pkg::cfg_t                      cfg_i,
  output logic                                res_valid_o,
  output scta_pkg::res_t                      res_o
);
  import scta_pkg::*;

  // Centre offset numerator: FRAME_WIDTH - 2*pos - size
  localparam int unsigned NUM_W  = ((COORD_BITS > 11) ? COORD_BITS : 11) + 3;
  localparam int unsigned PROD_W = NUM_W + GAIN_W + 1;
  // offset*gain*2^F vs window*2^25  ->  offset*gain vs window << (25 - F)
  localparam int unsigned SHIFT  = GAIN_FRAC_BITS + 1 - ANGLE_FRAC_BITS;
  localparam int unsigned WSH_W  = WIN_W + SHIFT + 1;
  localparam int unsigned CMP_W  = ((PROD_W > WSH_W) ? PROD_W : WSH_W) + 1;
  localparam int unsigned WIDE_W = ANGLE_W + 1;

  // State
  logic signed [ANGLE_W-1:0] angle_q, angle_d;
  logic                      sweep_up_q, sweep_up_d;
  logic                      seen_q, seen_d;
  logic signed [NUM_W-1:0]   num_x_q, num_y_q;
  logic [TICK_W-1:0]         seen_age_q, seen_age_d;
  logic [TICK_W-1:0]         shot_age_q, shot_age_d;
  logic                      armed_q, armed_d;

  logic signed [NUM_W-1:0]   num_x_new, num_y_new;
  logic signed [PROD_W-1:0]  gain_s;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic signed [CMP_W-1:0]   beta, alpha, hw, vw;
  logic signed [WIDE_W-1:0]  ang_w, step_w, lower_w, upper_w, next_w;
  logic [TICK_W-1:0]         seen_inc, shot_inc;
  logic                      tracking, up_dir, fire;
  logic [CODE_W-1:0]         code;

  assign num_x_new = NUM_W'(FRAME_WIDTH) - (NUM_W'(box_x_i) << 1) - NUM_W'(box_width_i);
  assign num_y_new = NUM_W'(FRAME_WIDTH) - (NUM_W'(box_y_i) << 1) - NUM_W'(box_height_i);

  assign gain_s = PROD_W'($signed({1'b0, cfg_i.pixel_gain}));
  assign prod_x = PROD_W'(num_x_q) * gain_s;
  assign prod_y = PROD_W'(num_y_q) * gain_s;
  assign beta   = CMP_W'(prod_x);
  assign alpha  = CMP_W'(prod_y);
  assign hw     = $signed(CMP_W'(cfg_i.h_window) << SHIFT);
  assign vw     = $signed(CMP_W'(cfg_i.v_window) << SHIFT);

  assign ang_w   = WIDE_W'(angle_q);
  assign step_w  = WIDE_W'($signed({1'b0, cfg_i.step_size}));
  assign lower_w = WIDE_W'(cfg_i.angle_lower);
  assign upper_w = WIDE_W'(cfg_i.angle_upper);

  assign seen_inc = (seen_age_q == AGE_MAX) ? seen_age_q : seen_age_q + 1'b1;
  assign shot_inc = (shot_age_q == AGE_MAX) ? shot_age_q : shot_age_q + 1'b1;
  assign tracking = seen_q && !(seen_inc > cfg_i.lost_timeout);

  always_comb begin
    next_w = ang_w;
    up_dir = sweep_up_q;
    fire   = 1'b0;
    code   = FIRE_NONE;
    if (tracking) begin
      if (beta > hw) begin
        next_w = ang_w + step_w;
        if (next_w >= upper_w) begin
          next_w = upper_w;
        end
      end else if (beta < -hw) begin
        next_w = ang_w - step_w;
        if (next_w <= lower_w) begin
          next_w = lower_w;
        end
      end
      if (beta < hw && beta > -hw && armed_q && shot_inc > cfg_i.fire_interval) begin
        fire = 1'b1;
        if (alpha >= 0) begin
          code = FIRE_HIGH;
        end else if (alpha > -vw) begin
          code = FIRE_MID;
        end else begin
          code = FIRE_LOW;
        end
      end
    end else begin
      if (ang_w >= upper_w) begin
        up_dir = 1'b0;
      end
      if (ang_w <= lower_w) begin
        up_dir = 1'b1;
      end
      next_w = up_dir ? ang_w + step_w : ang_w - step_w;
    end
  end

  always_comb begin
    angle_d    = angle_q;
    sweep_up_d = sweep_up_q;
    seen_d     = seen_q;
    seen_age_d = seen_age_q;
    shot_age_d = shot_age_q;
    armed_d    = armed_q;
    if (en_i) begin
      unique case (opcode_i)
        OP_TICK: begin
          angle_d    = next_w[ANGLE_W-1:0];
          sweep_up_d = up_dir;
          seen_d     = tracking;
          seen_age_d = seen_inc;
          shot_age_d = fire ? '0 : shot_inc;
        end
        OP_DETECT: begin
          seen_d     = 1'b1;
          seen_age_d = '0;
        end
        OP_FLAG: armed_d = (flag_value_i == FLAG_ARM);
        default: ;
      endcase
    end
  end

  assign res_valid_o      = (opcode_i == OP_TICK);
  assign res_o.aim_angle  = next_w[ANGLE_W-1:0];
  assign res_o.fire       = fire;
  assign res_o.fire_value = code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q    <= '0;
      sweep_up_q <= 1'b1;
      seen_q     <= 1'b0;
      seen_age_q <= '0;
      shot_age_q <= AGE_MAX;
      armed_q    <= 1'b0;
    end else begin
      angle_q    <= angle_d;
      sweep_up_q <= sweep_up_d;
      seen_q     <= seen_d;
      seen_age_q <= seen_age_d;
      shot_age_q <= shot_age_d;
      armed_q    <= armed_d;
    end
  end

  // Box is kept as its two centre-offset numerators
  always_ff @(posedge clk_i) begin
    if (en_i && opcode_i == OP_DETECT) begin
      num_x_q <= num_x_new;
      num_y_q <= num_y_new;
    end
  end

endmodule

// ===== rtl/scan_track_aim_controller_unit.sv =====
// Path: an accepted tick beat is held in the input register, then its result in the result register.
// Throughput: one event per cycle; stalls only when the result register is held.
// Critical path: stored offset times pixel gain, then window compare.
// Reset: angle 0, sweeping up, no target, disarmed, shot age saturated;
//   config registers return to their defaults. Detection and flag beats give no result.
// ----------------------------------------------------------------------------
// scan_track_aim_controller_unit
// Event-driven aim controller: sweep, track a detected box, issue fire codes.
// ----------------------------------------------------------------------------
`include "scan_track_aim_controller_unit_macros.svh"

module scan_track_aim_controller_unit #(
  parameter int unsigned FRAME_WIDTH     = scta_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned COORD_BITS      = scta_pkg::COORD_BITS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = scta_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // event channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [scta_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [COORD_BITS-1:0]                box_x_i,
  input  logic [COORD_BITS-1:0]                box_y_i,
  input  logic [COORD_BITS-1:0]                box_width_i,
  input  logic [COORD_BITS-1:0]                box_height_i,
  input  logic signed [scta_pkg::FLAG_W-1:0]   flag_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [scta_pkg::ANGLE_W-1:0]  aim_angle_o,
  output logic                                 fire_o,
  output logic [scta_pkg::CODE_W-1:0]          fire_value_o,
  // configuration channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [scta_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [scta_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import scta_pkg::*;

  cfg_t cfg;

  // Input register
  logic                     in_valid_q;
  logic [OPCODE_W-1:0]      opcode_q;
  logic [COORD_BITS-1:0]    box_x_q, box_y_q, box_width_q, box_height_q;
  logic signed [FLAG_W-1:0] flag_value_q;

  // Result register
  logic out_valid_q, out_valid_d;
  res_t res_q;

  logic out_free, proc, in_take, res_valid;
  res_t res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  scta_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  scta_aim_core #(
    .FRAME_WIDTH     (FRAME_WIDTH),
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (proc),
    .opcode_i     (opcode_q),
    .box_x_i      (box_x_q),
    .box_y_i      (box_y_q),
    .box_width_i  (box_width_q),
    .box_height_i (box_height_q),
    .flag_value_i (flag_value_q),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = proc && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q     <= opcode_i;
      box_x_q      <= box_x_i;
      box_y_q      <= box_y_i;
      box_width_q  <= box_width_i;
      box_height_q <= box_height_i;
      flag_value_q <= flag_value_i;
    end
    if (proc && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign aim_angle_o  = res_q.aim_angle;
  assign fire_o       = res_q.fire;
  assign fire_value_o = res_q.fire_value;

  `SCTA_ASSERT_IMP(a_fire_code, clk_i, rst_ni, out_valid_q && res_q.fire, res_q.fire_value == FIRE_HIGH || res_q.fire_value == FIRE_MID || res_q.fire_value == FIRE_LOW, "fire beat without a valid code")
  `SCTA_ASSERT_IMP(a_no_fire_zero, clk_i, rst_ni, out_valid_q && !res_q.fire, res_q.fire_value == FIRE_NONE, "nonzero code without a shot")
  `SCTA_ASSERT_NXT(a_silent_event, clk_i, rst_ni, proc && opcode_q != OP_TICK, !out_valid_q, "non-tick event produced a result")

endmodule
